### sv/assert_macros.svh
// assertion macros used by the checker sit_checker
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define SIT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

// consequent checked in the same cycle as the antecedent
`define SIT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

`endif

### sv/sit_pkg.sv
// shared types and constants for the segment intersection test
// no dependencies
package sit_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 32;

  // orientation of an ordered point triple
  typedef enum logic [1:0] {
    ORI_COL,
    ORI_CW,
    ORI_CCW
  } orient_t;

  // load enables for the pipeline stages inside the orientation unit
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

### sv/sit_orient.sv
// orientation unit: sign of (qy-py)*(rx-qx) - (qx-px)*(ry-qy)
// three register stages: differences, split partial products, full products
// depends on sit_pkg
module sit_orient import sit_pkg::*; #(
  parameter int DIFF_BITS = COORD_BITS_DEF + 1
) (
  input  logic                        clk,
  input  pipe_en_t                    en,
  input  logic signed [DIFF_BITS-1:0] d_qy_py,
  input  logic signed [DIFF_BITS-1:0] d_rx_qx,
  input  logic signed [DIFF_BITS-1:0] d_qx_px,
  input  logic signed [DIFF_BITS-1:0] d_ry_qy,
  output orient_t                     ori
);

  // second operand is split into an unsigned low half and a signed high half
  localparam int LoBits = (DIFF_BITS + 1) / 2;
  localparam int LoW    = LoBits + 1;
  localparam int HiW    = DIFF_BITS - LoBits;
  localparam int PlW    = DIFF_BITS + LoW;
  localparam int PhW    = DIFF_BITS + HiW;
  localparam int PrW    = 2 * DIFF_BITS;

  logic signed [DIFF_BITS-1:0] a1_r, b1_r, a2_r, b2_r;
  logic signed [LoW-1:0]       lo1, lo2;
  logic signed [HiW-1:0]       hi1, hi2;
  logic signed [PlW-1:0]       pl1_r, pl2_r;
  logic signed [PhW-1:0]       ph1_r, ph2_r;
  logic signed [PrW-1:0]       pr1_r, pr2_r;

  // difference register
  always_ff @(posedge clk) begin
    if (en.s1) begin
      a1_r <= d_qy_py;
      b1_r <= d_rx_qx;
      a2_r <= d_qx_px;
      b2_r <= d_ry_qy;
    end
  end

  // operand halves
  assign lo1 = $signed({1'b0, b1_r[LoBits-1:0]});
  assign lo2 = $signed({1'b0, b2_r[LoBits-1:0]});
  assign hi1 = $signed(b1_r[DIFF_BITS-1:LoBits]);
  assign hi2 = $signed(b2_r[DIFF_BITS-1:LoBits]);

  // partial products
  always_ff @(posedge clk) begin
    if (en.s2) begin
      pl1_r <= PlW'(a1_r) * PlW'(lo1);
      ph1_r <= PhW'(a1_r) * PhW'(hi1);
      pl2_r <= PlW'(a2_r) * PlW'(lo2);
      ph2_r <= PhW'(a2_r) * PhW'(hi2);
    end
  end

  // recombine partials into full products
  always_ff @(posedge clk) begin
    if (en.s3) begin
      pr1_r <= (PrW'(ph1_r) <<< LoBits) + PrW'(pl1_r);
      pr2_r <= (PrW'(ph2_r) <<< LoBits) + PrW'(pl2_r);
    end
  end

  // sign of the determinant from one signed compare
  always_comb begin
    if (pr1_r == pr2_r) begin
      ori = ORI_COL;
    end else if (pr1_r > pr2_r) begin
      ori = ORI_CW;
    end else begin
      ori = ORI_CCW;
    end
  end

endmodule

### sv/segment_intersection_test_top.sv
// Segment intersection test: tells whether two closed 2D segments given as
// signed fixed-point endpoints meet, using four exact orientation signs plus
// bounding-box checks for collinear points; with in_skip_shared_ends set,
// segments sharing an endpoint report no hit. The block is a five-register
// pipeline (input, coordinate differences, half-width partial products, full
// products, result) and takes one transaction per clock while out_ready is
// high. Each result passes through all five registers; while out_ready is low,
// empty pipeline stages keep absorbing input until all five registers are full.
// The product stage sets the clock: each cross product is formed as two
// partial products of about half width.
// depends on sit_pkg and sit_orient
module segment_intersection_test_top import sit_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_a_start_x,
  input  logic signed [COORD_BITS-1:0] in_a_start_y,
  input  logic signed [COORD_BITS-1:0] in_a_end_x,
  input  logic signed [COORD_BITS-1:0] in_a_end_y,
  input  logic signed [COORD_BITS-1:0] in_b_start_x,
  input  logic signed [COORD_BITS-1:0] in_b_start_y,
  input  logic signed [COORD_BITS-1:0] in_b_end_x,
  input  logic signed [COORD_BITS-1:0] in_b_end_y,
  input  logic                         in_skip_shared_ends,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit
);

  localparam int DiffBits = COORD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]   diff_t;

  // stage enables and valid bits
  logic     en0, en1, en2, en3, en_out;
  logic     v0_r, v1_r, v2_r, v3_r, out_valid_r, out_hit_r;
  logic     hit_nxt;
  pipe_en_t pen;

  // input register
  coord_t asx_r, asy_r, aex_r, aey_r, bsx_r, bsy_r, bex_r, bey_r;
  logic   skip_r;

  // side flags travelling with the transaction
  logic [3:0] box_nxt, box1_r, box2_r, box3_r;
  logic       blk_nxt, blk1_r, blk2_r, blk3_r;

  orient_t o1, o2, o3, o4;

  function automatic diff_t sub_d(input coord_t x, input coord_t y);
    sub_d = DiffBits'(x) - DiffBits'(y);
  endfunction

  // q inside the bounding box spanned by p and r
  function automatic logic in_box(input coord_t px, input coord_t py, input coord_t qx,
                                  input coord_t qy, input coord_t rx, input coord_t ry);
    logic okx, oky;
    okx = (qx >= px && qx <= rx) || (qx >= rx && qx <= px);
    oky = (qy >= py && qy <= ry) || (qy >= ry && qy <= py);
    in_box = okx && oky;
  endfunction

  // a stage loads when it is empty or its successor moves on
  assign en_out   = !out_valid_r || out_ready;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;
  assign pen      = '{s1: en1, s2: en2, s3: en3};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0)    v0_r        <= in_valid;
      if (en1)    v1_r        <= v0_r;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en0) begin
      asx_r  <= in_a_start_x;
      asy_r  <= in_a_start_y;
      aex_r  <= in_a_end_x;
      aey_r  <= in_a_end_y;
      bsx_r  <= in_b_start_x;
      bsy_r  <= in_b_start_y;
      bex_r  <= in_b_end_x;
      bey_r  <= in_b_end_y;
      skip_r <= in_skip_shared_ends;
    end
  end

  // shared endpoint block and collinear bounding-box checks
  always_comb begin
    blk_nxt = skip_r && ((asx_r == bsx_r && asy_r == bsy_r) ||
                         (asx_r == bex_r && asy_r == bey_r) ||
                         (aex_r == bsx_r && aey_r == bsy_r) ||
                         (aex_r == bex_r && aey_r == bey_r));
    box_nxt[0] = in_box(asx_r, asy_r, bsx_r, bsy_r, aex_r, aey_r);
    box_nxt[1] = in_box(asx_r, asy_r, bex_r, bey_r, aex_r, aey_r);
    box_nxt[2] = in_box(bsx_r, bsy_r, asx_r, asy_r, bex_r, bey_r);
    box_nxt[3] = in_box(bsx_r, bsy_r, aex_r, aey_r, bex_r, bey_r);
  end

  // flags follow the orientation pipeline
  always_ff @(posedge clk) begin
    if (en1) begin
      box1_r <= box_nxt;
      blk1_r <= blk_nxt;
    end
    if (en2) begin
      box2_r <= box1_r;
      blk2_r <= blk1_r;
    end
    if (en3) begin
      box3_r <= box2_r;
      blk3_r <= blk2_r;
    end
  end

  // orientation of b start against segment a
  sit_orient #(.DIFF_BITS(DiffBits)) u_ori1 (
    .clk     (clk),
    .en      (pen),
    .d_qy_py (sub_d(aey_r, asy_r)),
    .d_rx_qx (sub_d(bsx_r, aex_r)),
    .d_qx_px (sub_d(aex_r, asx_r)),
    .d_ry_qy (sub_d(bsy_r, aey_r)),
    .ori     (o1)
  );

  // orientation of b end against segment a
  sit_orient #(.DIFF_BITS(DiffBits)) u_ori2 (
    .clk     (clk),
    .en      (pen),
    .d_qy_py (sub_d(aey_r, asy_r)),
    .d_rx_qx (sub_d(bex_r, aex_r)),
    .d_qx_px (sub_d(aex_r, asx_r)),
    .d_ry_qy (sub_d(bey_r, aey_r)),
    .ori     (o2)
  );

  // orientation of a start against segment b
  sit_orient #(.DIFF_BITS(DiffBits)) u_ori3 (
    .clk     (clk),
    .en      (pen),
    .d_qy_py (sub_d(bey_r, bsy_r)),
    .d_rx_qx (sub_d(asx_r, bex_r)),
    .d_qx_px (sub_d(bex_r, bsx_r)),
    .d_ry_qy (sub_d(asy_r, bey_r)),
    .ori     (o3)
  );

  // orientation of a end against segment b
  sit_orient #(.DIFF_BITS(DiffBits)) u_ori4 (
    .clk     (clk),
    .en      (pen),
    .d_qy_py (sub_d(bey_r, bsy_r)),
    .d_rx_qx (sub_d(aex_r, bex_r)),
    .d_qx_px (sub_d(bex_r, bsx_r)),
    .d_ry_qy (sub_d(aey_r, bey_r)),
    .ori     (o4)
  );

  // general crossing or a collinear point on the other segment
  assign hit_nxt = !blk3_r && ((o1 != o2 && o3 != o4) ||
                               (o1 == ORI_COL && box3_r[0]) ||
                               (o2 == ORI_COL && box3_r[1]) ||
                               (o3 == ORI_COL && box3_r[2]) ||
                               (o4 == ORI_COL && box3_r[3]));

  // result register
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

### sv/sit_checker.sv
// port-level checks for segment_intersection_test_top, bound to the top level
// depends on sit_pkg and assert_macros.svh
`include "assert_macros.svh"

module sit_checker import sit_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [COORD_BITS-1:0] in_a_start_x,
  input logic signed [COORD_BITS-1:0] in_a_start_y,
  input logic signed [COORD_BITS-1:0] in_a_end_x,
  input logic signed [COORD_BITS-1:0] in_a_end_y,
  input logic signed [COORD_BITS-1:0] in_b_start_x,
  input logic signed [COORD_BITS-1:0] in_b_start_y,
  input logic signed [COORD_BITS-1:0] in_b_end_x,
  input logic signed [COORD_BITS-1:0] in_b_end_y,
  input logic                         in_skip_shared_ends,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_hit
);

  logic acc_w, run_w, shr_w, same_w;

  // accepted transaction outside reset
  assign acc_w = in_valid && in_ready && rst_n;
  // output side draining freely
  assign run_w = rst_n && out_ready;
  // shared start point with the skip flag set
  assign shr_w = in_skip_shared_ends && in_a_start_x == in_b_start_x &&
                 in_a_start_y == in_b_start_y;
  // identical segments with the skip flag clear
  assign same_w = !in_skip_shared_ends && in_a_start_x == in_b_start_x &&
                  in_a_start_y == in_b_start_y && in_a_end_x == in_b_end_x &&
                  in_a_end_y == in_b_end_y;

  // stalled result holds
  `SIT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit))

  // nothing pending right after reset
  `SIT_ASSERT_NOW(a_rst_empty, $past(!rst_n), !out_valid)

  // result valid after a free-flowing pass through all pipeline registers
  `SIT_ASSERT_NEXT(a_latency, $past(acc_w, 4) && $past(run_w, 3) && $past(run_w, 2) && $past(run_w, 1) && run_w, out_valid)

  // shared start point with skip set never hits
  `SIT_ASSERT_NEXT(a_shared_miss, $past(acc_w && shr_w, 4) && $past(run_w, 3) && $past(run_w, 2) && $past(run_w, 1) && run_w, !out_hit)

  // a segment always meets itself
  `SIT_ASSERT_NEXT(a_same_hit, $past(acc_w && same_w, 4) && $past(run_w, 3) && $past(run_w, 2) && $past(run_w, 1) && run_w, out_hit)

endmodule

bind segment_intersection_test_top sit_checker #(.COORD_BITS(COORD_BITS)) u_sit_checker (.*);
